// ===== src/char_lcd_4bit_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// char_lcd_4bit_sequencer_macros.svh
// Assertion macros used by the char_lcd_4bit_sequencer module.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_4BIT_SEQUENCER_MACROS_SVH
`define CHAR_LCD_4BIT_SEQUENCER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CLCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the following cycle.
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// clcd_pkg
// Types and constants for the character-LCD 4-bit bus sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

    // Request codes carried on the slave-side tuser
    typedef enum logic [2:0] {
        REQ_CMD    = 3'd0,
        REQ_DATA   = 3'd1,
        REQ_CURSOR = 3'd2,
        REQ_INIT   = 3'd3,
        REQ_CLEAR  = 3'd4,
        REQ_NORMAL = 3'd5,
        REQ_BLINK  = 3'd6
    } req_type_t;

    // Bus action kinds
    typedef enum logic [1:0] {
        ACT_STROBE = 2'd0,
        ACT_BUSY   = 2'd1,
        ACT_DELAY  = 2'd2
    } act_kind_t;

    // Nibble source select
    typedef enum logic [2:0] {
        NIB_CONST   = 3'd0,
        NIB_BYTE_HI = 3'd1,
        NIB_BYTE_LO = 3'd2,
        NIB_ADDR_HI = 3'd3,
        NIB_ADDR_LO = 3'd4
    } nib_sel_t;

    // Delay source select
    typedef enum logic [1:0] {
        DLY_NONE  = 2'd0,
        DLY_LONG  = 2'd1,
        DLY_SHORT = 2'd2
    } dly_sel_t;

    // Sequencing op: step on, end the run, or end unless blink (then jump)
    typedef enum logic [1:0] {
        SEQ_NEXT     = 2'd0,
        SEQ_END      = 2'd1,
        SEQ_END_JMPB = 2'd2
    } seq_op_t;

    localparam int UC_DEPTH = 32;
    localparam int PC_W     = $clog2(UC_DEPTH);

    typedef logic [PC_W-1:0] pc_t;

    // One microcode control word
    typedef struct packed {
        act_kind_t   kind;
        logic        rs;
        nib_sel_t    nib_sel;
        logic [3:0]  nib_const;
        dly_sel_t    dly_sel;
        seq_op_t     seq;
    } ctl_word_t;

    // Program entry points
    localparam pc_t UC_CMD        = 5'd0;
    localparam pc_t UC_DATA       = 5'd2;
    localparam pc_t UC_CURSOR     = 5'd5;
    localparam pc_t UC_BLINK_TAIL = 5'd8;
    localparam pc_t UC_NORMAL     = 5'd11;
    localparam pc_t UC_INIT       = 5'd14;
    localparam pc_t UC_CLEAR      = 5'd25;

    // Configuration register indexes
    localparam logic CFG_LONG_DELAY  = 1'b0;
    localparam logic CFG_SHORT_DELAY = 1'b1;

    localparam logic [7:0] LONG_DELAY_RST  = 8'd20;
    localparam logic [7:0] SHORT_DELAY_RST = 8'd5;

    // Display address constants
    localparam logic [7:0] LINE2_OFFSET = 8'h40;
    localparam logic [7:0] DDRAM_SET    = 8'h80;
    localparam logic [7:0] LINE2_SEL    = 8'd2;

endpackage

// ===== src/clcd_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// clcd_ucode_rom
// Microcode store and dispatch table of the LCD sequencer.
// ----------------------------------------------------------------------------
module clcd_ucode_rom
    import clcd_pkg::*;
(
    input  pc_t         pc,
    input  logic [2:0]  req_type,
    output ctl_word_t   word,
    output pc_t         entry_pc,
    output logic        entry_valid
);

    function automatic ctl_word_t mk(act_kind_t k, logic rs, nib_sel_t ns,
                                     logic [3:0] nc, dly_sel_t ds, seq_op_t sq);
        ctl_word_t w;
        w.kind      = k;
        w.rs        = rs;
        w.nib_sel   = ns;
        w.nib_const = nc;
        w.dly_sel   = ds;
        w.seq       = sq;
        return w;
    endfunction

    // Control words, one per step
    always_comb
    begin
        case (pc)
            // raw command
            5'd0:  word = mk(ACT_STROBE, 1'b0, NIB_BYTE_HI, 4'h0, DLY_NONE, SEQ_NEXT);
            5'd1:  word = mk(ACT_STROBE, 1'b0, NIB_BYTE_LO, 4'h0, DLY_NONE, SEQ_END);
            // data character
            5'd2:  word = mk(ACT_BUSY,   1'b0, NIB_CONST,   4'h0, DLY_NONE, SEQ_NEXT);
            5'd3:  word = mk(ACT_STROBE, 1'b1, NIB_BYTE_HI, 4'h0, DLY_NONE, SEQ_NEXT);
            5'd4:  word = mk(ACT_STROBE, 1'b1, NIB_BYTE_LO, 4'h0, DLY_NONE, SEQ_END);
            // set cursor; blink continues at the tail
            5'd5:  word = mk(ACT_BUSY,   1'b0, NIB_CONST,   4'h0, DLY_NONE, SEQ_NEXT);
            5'd6:  word = mk(ACT_STROBE, 1'b0, NIB_ADDR_HI, 4'h0, DLY_NONE, SEQ_NEXT);
            5'd7:  word = mk(ACT_STROBE, 1'b0, NIB_ADDR_LO, 4'h0, DLY_NONE, SEQ_END_JMPB);
            // blink tail: instruction 0x0F
            5'd8:  word = mk(ACT_BUSY,   1'b0, NIB_CONST,   4'h0, DLY_NONE, SEQ_NEXT);
            5'd9:  word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h0, DLY_NONE, SEQ_NEXT);
            5'd10: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'hF, DLY_NONE, SEQ_END);
            // normal cursor: instruction 0x0C
            5'd11: word = mk(ACT_BUSY,   1'b0, NIB_CONST,   4'h0, DLY_NONE, SEQ_NEXT);
            5'd12: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h0, DLY_NONE, SEQ_NEXT);
            5'd13: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'hC, DLY_NONE, SEQ_END);
            // power-on init, falls through into clear
            5'd14: word = mk(ACT_DELAY,  1'b0, NIB_CONST,   4'h0, DLY_LONG,  SEQ_NEXT);
            5'd15: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h3, DLY_NONE,  SEQ_NEXT);
            5'd16: word = mk(ACT_DELAY,  1'b0, NIB_CONST,   4'h0, DLY_SHORT, SEQ_NEXT);
            5'd17: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h3, DLY_NONE,  SEQ_NEXT);
            5'd18: word = mk(ACT_DELAY,  1'b0, NIB_CONST,   4'h0, DLY_SHORT, SEQ_NEXT);
            5'd19: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h3, DLY_NONE,  SEQ_NEXT);
            5'd20: word = mk(ACT_DELAY,  1'b0, NIB_CONST,   4'h0, DLY_SHORT, SEQ_NEXT);
            5'd21: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h2, DLY_NONE,  SEQ_NEXT);
            5'd22: word = mk(ACT_DELAY,  1'b0, NIB_CONST,   4'h0, DLY_SHORT, SEQ_NEXT);
            5'd23: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h2, DLY_NONE,  SEQ_NEXT);
            5'd24: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h8, DLY_NONE,  SEQ_NEXT);
            // clear: 0x01, long delay, 0x0C
            5'd25: word = mk(ACT_BUSY,   1'b0, NIB_CONST,   4'h0, DLY_NONE,  SEQ_NEXT);
            5'd26: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h0, DLY_NONE,  SEQ_NEXT);
            5'd27: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h1, DLY_NONE,  SEQ_NEXT);
            5'd28: word = mk(ACT_DELAY,  1'b0, NIB_CONST,   4'h0, DLY_LONG,  SEQ_NEXT);
            5'd29: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'h0, DLY_NONE,  SEQ_NEXT);
            5'd30: word = mk(ACT_STROBE, 1'b0, NIB_CONST,   4'hC, DLY_NONE,  SEQ_END);
            default: word = mk(ACT_BUSY, 1'b0, NIB_CONST,   4'h0, DLY_NONE,  SEQ_END);
        endcase
    end

    // Dispatch on request type; the unused code starts no run
    always_comb
    begin
        entry_valid = 1'b1;
        case (req_type)
            REQ_CMD:    entry_pc = UC_CMD;
            REQ_DATA:   entry_pc = UC_DATA;
            REQ_CURSOR: entry_pc = UC_CURSOR;
            REQ_INIT:   entry_pc = UC_INIT;
            REQ_CLEAR:  entry_pc = UC_CLEAR;
            REQ_NORMAL: entry_pc = UC_NORMAL;
            REQ_BLINK:  entry_pc = UC_CURSOR;
            default:
            begin
                entry_pc    = UC_CMD;
                entry_valid = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/char_lcd_4bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_4bit_sequencer
// Expands character-LCD requests into runs of 4-bit bus actions.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat on the slave stream (s_axis_*) is expanded into a run of
//   bus actions on the master stream (m_axis_*), one action per beat, with
//   tlast on the final action. Actions are nibble strobes, busy waits and
//   millisecond delays; the downstream bus driver carries them out.
//   The request is registered into the step counter, and each control word
//   is then registered into the output register as an action. Throughput:
//   one action per cycle when the receiver is ready; the input is held off
//   while a run is in progress (init: 17 actions). The rate is set by the
//   step counter, which issues one control word per cycle when not stalled.
//   The input is ready whenever no run is in progress, also while the last
//   action still waits in the output register. Request type 7 is taken and
//   produces nothing.
//   When the receiver stalls, the step counter holds and the pending action
//   stays in the output register.
//   Reset clears the run and output valid, and loads the delay registers
//   with 20 ms (long) and 5 ms (short). Write them only while idle.
// ----------------------------------------------------------------------------
`include "char_lcd_4bit_sequencer_macros.svh"

module char_lcd_4bit_sequencer
    import clcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,

    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // byte_value[7:0], line_number[15:8],
                                        // column_position[22:16], zero pad
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]

    // action stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // nibble[3:0], delay_ms[11:4], zero pad
    output logic [2:0]  m_axis_tuser,   // action_kind[1:0], register_select[2]
    output logic        m_axis_tlast
);

    // control state
    logic        busy_reg, busy_next;
    pc_t         pc_reg, pc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  long_dly_reg, long_dly_next;
    logic [7:0]  short_dly_reg, short_dly_next;

    // payload
    logic [7:0]  byte_reg, byte_next;
    logic [7:0]  addr_reg, addr_next;
    logic        blink_reg, blink_next;
    act_kind_t   kind_reg, kind_next;
    logic        rs_reg, rs_next;
    logic [3:0]  nib_reg, nib_next;
    logic [7:0]  dly_reg, dly_next;
    logic        last_reg, last_next;

    ctl_word_t   word;
    pc_t         entry_pc;
    logic        entry_valid;
    logic        in_fire;
    logic        emit;
    logic        step_last;
    logic [7:0]  col_ext;
    logic [7:0]  line_off;

    clcd_ucode_rom u_rom (
        .pc          (pc_reg),
        .req_type    (s_axis_tuser),
        .word        (word),
        .entry_pc    (entry_pc),
        .entry_valid (entry_valid)
    );

    assign s_axis_tready = !busy_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign emit          = busy_reg && (!out_valid_reg || m_axis_tready);

    // run ends here, or continues at the blink tail for a blink request
    assign step_last = (word.seq == SEQ_END) || ((word.seq == SEQ_END_JMPB) && !blink_reg);

    // display address: (column - 1) + line offset + set-address bit, mod 256
    assign col_ext  = {1'b0, s_axis_tdata[22:16]};
    assign line_off = (s_axis_tdata[15:8] == LINE2_SEL) ? LINE2_OFFSET : 8'h00;

    // sequencer and configuration next state
    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        long_dly_next  = long_dly_reg;
        short_dly_next = short_dly_reg;
        byte_next      = byte_reg;
        addr_next      = addr_reg;
        blink_next     = blink_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_LONG_DELAY:  long_dly_next  = cfg_wdata;
                CFG_SHORT_DELAY: short_dly_next = cfg_wdata;
                default:         long_dly_next  = long_dly_reg;
            endcase
        end

        if (in_fire)
        begin
            byte_next  = s_axis_tdata[7:0];
            addr_next  = col_ext - 8'd1 + line_off + DDRAM_SET;
            blink_next = (s_axis_tuser == REQ_BLINK);
            busy_next  = entry_valid;
            pc_next    = entry_pc;
        end
        else if (emit)
        begin
            if (step_last)
                busy_next = 1'b0;
            else if (word.seq == SEQ_END_JMPB)
                pc_next = UC_BLINK_TAIL;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    // datapath: build the action from the control word
    always_comb
    begin
        kind_next = kind_reg;
        rs_next   = rs_reg;
        nib_next  = nib_reg;
        dly_next  = dly_reg;
        last_next = last_reg;

        if (emit)
        begin
            kind_next = word.kind;
            rs_next   = word.rs;
            last_next = step_last;
            case (word.nib_sel)
                NIB_BYTE_HI: nib_next = byte_reg[7:4];
                NIB_BYTE_LO: nib_next = byte_reg[3:0];
                NIB_ADDR_HI: nib_next = addr_reg[7:4];
                NIB_ADDR_LO: nib_next = addr_reg[3:0];
                default:     nib_next = word.nib_const;
            endcase
            case (word.dly_sel)
                DLY_LONG:  dly_next = long_dly_reg;
                DLY_SHORT: dly_next = short_dly_reg;
                default:   dly_next = 8'h00;
            endcase
        end
    end

    // output valid
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= UC_CMD;
            out_valid_reg <= 1'b0;
            long_dly_reg  <= LONG_DELAY_RST;
            short_dly_reg <= SHORT_DELAY_RST;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            long_dly_reg  <= long_dly_next;
            short_dly_reg <= short_dly_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        addr_reg  <= addr_next;
        blink_reg <= blink_next;
        kind_reg  <= kind_next;
        rs_reg    <= rs_next;
        nib_reg   <= nib_next;
        dly_reg   <= dly_next;
        last_reg  <= last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'h0, dly_reg, nib_reg};
    assign m_axis_tuser  = {rs_reg, kind_reg};
    assign m_axis_tlast  = last_reg;

    // assertions
    `CLCD_ASSERT_NEXT(a_step_issues, emit, m_axis_tvalid,
        "step issued but no action valid")
    `CLCD_ASSERT_NEXT(a_last_ends_run, emit && step_last, !busy_reg && m_axis_tlast,
        "final step did not end the run")
    `CLCD_ASSERT_NEXT(a_unused_req_idle, in_fire && !entry_valid, s_axis_tready && !busy_reg,
        "unused request type started a run")
    `CLCD_ASSERT(a_non_strobe_clean,
        !m_axis_tvalid || (m_axis_tuser[1:0] == ACT_STROBE) ||
        ((m_axis_tdata[3:0] == 4'h0) && (m_axis_tuser[2] == 1'b0)),
        "non-strobe action carries nibble or register select")
    `CLCD_ASSERT(a_delay_only_on_delay,
        !m_axis_tvalid || (m_axis_tuser[1:0] == ACT_DELAY) || (m_axis_tdata[11:4] == 8'h00),
        "delay value on a non-delay action")

endmodule
